@@ src/fpp_pkg.sv @@
// shared sizes, types and state codes of the farthest point pair block
package fpp_pkg;

   localparam int MAX_POINTS     = 4096;
   localparam int COORD_BITS     = 24;

   localparam int IDX_BITS       = $clog2(MAX_POINTS);
   localparam int CNT_BITS       = $clog2(MAX_POINTS + 1);
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * COORD_BITS;
   localparam int SUM_BITS       = PROD_BITS + 2;
   localparam int KEEP_BITS      = (SUM_BITS > 64) ? 64 : SUM_BITS;
   localparam int ROOT_BITS      = (KEEP_BITS + 1) / 2;
   localparam int RAD_BITS       = 2 * ROOT_BITS;
   localparam int ROOT_CNT_BITS  = $clog2(ROOT_BITS);

   localparam int OUT_INDEX_BITS = 12;
   localparam int OUT_SQ_BITS    = 50;
   localparam int OUT_DIST_BITS  = 25;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD_I,
      ST_GET_I,
      ST_DX,
      ST_DY,
      ST_DZ,
      ST_CMP,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_FINISH
   } fpp_state_type;

endpackage

@@ src/fpp_channels.sv @@
// point and result channel interfaces
interface fpp_req_if;
   import fpp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic                         last_point;

   modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface fpp_rsp_if;
   import fpp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OUT_INDEX_BITS-1:0]    first_index;
   logic [OUT_INDEX_BITS-1:0]    second_index;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] first_z;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic signed [COORD_BITS-1:0] second_z;
   logic [OUT_SQ_BITS-1:0]       squared_distance;
   logic [OUT_DIST_BITS-1:0]     distance;
   logic                         pair_found;
   logic                         points_dropped;

   modport source (
      output valid, first_index, second_index, first_x, first_y, first_z,
             second_x, second_y, second_z, squared_distance, distance,
             pair_found, points_dropped,
      input  ready
   );
   modport sink (
      input  valid, first_index, second_index, first_x, first_y, first_z,
             second_x, second_y, second_z, squared_distance, distance,
             pair_found, points_dropped,
      output ready
   );
endinterface

@@ src/fpp_point_mem.sv @@
// point store: one write port, one registered read port
module fpp_point_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [fpp_pkg::IDX_BITS-1:0] wr_addr,
   input  fpp_pkg::point_type           wr_data,
   input  logic                         rd_en,
   input  logic [fpp_pkg::IDX_BITS-1:0] rd_addr,
   output fpp_pkg::point_type           rd_data
);
   import fpp_pkg::*;

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fpp_sq_unit.sv @@
// shared squared-difference unit: one coordinate of a pair per cycle, product registered
module fpp_sq_unit (
   input  logic                          clock,
   input  fpp_pkg::point_type            point_a,
   input  fpp_pkg::point_type            point_b,
   input  fpp_pkg::axis_type             axis_sel,
   output logic [fpp_pkg::PROD_BITS-1:0] sq_prod
);
   import fpp_pkg::*;

   logic signed [COORD_BITS-1:0] coord_a;
   logic signed [COORD_BITS-1:0] coord_b;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [DIFF_BITS-1:0]  diff_neg;
   logic [COORD_BITS-1:0]        mag;
   logic [PROD_BITS-1:0]         sq_ff;
   logic [PROD_BITS-1:0]         sq_in;

   always_comb begin
      case (axis_sel)
         AXIS_X: begin
            coord_a = point_a.x;
            coord_b = point_b.x;
         end
         AXIS_Y: begin
            coord_a = point_a.y;
            coord_b = point_b.y;
         end
         AXIS_Z: begin
            coord_a = point_a.z;
            coord_b = point_b.z;
         end
         default: begin
            coord_a = point_a.x;
            coord_b = point_b.x;
         end
      endcase
   end

   // |a - b| always fits the coordinate width
   assign diff     = DIFF_BITS'(coord_a) - DIFF_BITS'(coord_b);
   assign diff_neg = -diff;
   assign mag      = diff[DIFF_BITS-1] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
   assign sq_in    = PROD_BITS'(mag) * PROD_BITS'(mag);

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sq_prod = sq_ff;

endmodule

@@ src/fpp_isqrt.sv @@
// floor square root, one result bit per cycle
module fpp_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fpp_pkg::KEEP_BITS-1:0] radicand,
   output logic                          done,
   output logic [fpp_pkg::ROOT_BITS-1:0] root
);
   import fpp_pkg::*;

   logic                     busy_ff,  busy_in;
   logic                     done_ff,  done_in;
   logic [ROOT_CNT_BITS-1:0] cnt_ff,   cnt_in;
   logic [RAD_BITS-1:0]      rad_ff,   rad_in;
   logic [ROOT_BITS:0]       rem_ff,   rem_in;
   logic [ROOT_BITS-1:0]     root_ff,  root_in;
   logic [ROOT_BITS+1:0]     rem_shift;
   logic [ROOT_BITS+1:0]     trial;
   logic [ROOT_BITS+1:0]     rem_diff;
   logic                     take;

   assign rem_shift = {rem_ff[ROOT_BITS-1:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);
   assign rem_diff  = take ? (rem_shift - trial) : rem_shift;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ROOT_CNT_BITS'(ROOT_BITS - 1);
         rad_in  = RAD_BITS'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
         rem_in  = rem_diff[ROOT_BITS:0];
         root_in = {root_ff[ROOT_BITS-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ src/farthest_point_pair.sv @@
// farthest point pair: loads a 3d point set and finds the pair at the largest distance
// Points are taken one beat per cycle while the block is idle and written to a
// 4096-entry point store in load order; a beat with last_point set closes the set
// (beats past the store's capacity are dropped and flagged). The block then drops
// req ready and walks every pair i<j through one shared squaring multiplier, three
// coordinates in turn; a bit-serial square root then follows. The result beat waits
// in an output register, so the next set can load while it is unclaimed.
module farthest_point_pair (
   input  logic      clock,
   input  logic      reset,
   fpp_req_if.sink   req_bus,
   fpp_rsp_if.source rsp_bus
);
   import fpp_pkg::*;

   typedef struct packed {
      logic [OUT_INDEX_BITS-1:0] first_index;
      logic [OUT_INDEX_BITS-1:0] second_index;
      point_type                 first_pt;
      point_type                 second_pt;
      logic [OUT_SQ_BITS-1:0]    squared;
      logic [OUT_DIST_BITS-1:0]  distance;
      logic                      found;
      logic                      dropped;
   } result_type;

   fpp_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]  point_count_ff, point_count_in;
   logic                 overflow_ff, overflow_in;
   logic [CNT_BITS-1:0]  i_ff, i_in;
   logic [CNT_BITS-1:0]  j_ff, j_in;
   point_type            pi_ff, pi_in;
   logic [SUM_BITS-1:0]  acc_ff, acc_in;
   logic [KEEP_BITS-1:0] best_sq_ff, best_sq_in;
   logic [IDX_BITS-1:0]  best_first_ff, best_first_in;
   logic [IDX_BITS-1:0]  best_second_ff, best_second_in;
   point_type            best_pi_ff, best_pi_in;
   point_type            best_pj_ff, best_pj_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 slot_free;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [IDX_BITS-1:0]  mem_rd_addr;
   point_type            mem_wr_data;
   point_type            mem_rd_data;
   axis_type             axis_sel;
   logic [PROD_BITS-1:0] sq_prod;
   logic                 root_start;
   logic                 root_done;
   logic [ROOT_BITS-1:0] root;
   logic [CNT_BITS-1:0]  i_plus1;
   logic [CNT_BITS-1:0]  i_plus2;
   logic [CNT_BITS-1:0]  j_plus1;
   logic [SUM_BITS-1:0]  total;
   logic                 total_sat;
   logic [KEEP_BITS-1:0] total_keep;
   logic                 found;

   assign req_accept  = req_bus.valid && req_bus.ready;
   assign slot_free   = !rsp_valid_ff || rsp_bus.ready;
   assign mem_wr_data = '{x: req_bus.coord_x, y: req_bus.coord_y, z: req_bus.coord_z};
   assign i_plus1     = i_ff + 1'b1;
   assign i_plus2     = i_ff + CNT_BITS'(2);
   assign j_plus1     = j_ff + 1'b1;

   // sum of squares, clamped where it would pass 64 bits
   assign total       = acc_ff + SUM_BITS'(sq_prod);
   assign total_sat   = (SUM_BITS > KEEP_BITS) && ((total >> KEEP_BITS) != '0);
   assign total_keep  = total_sat ? '1 : KEEP_BITS'(total);
   assign found       = (best_sq_ff != '0);

   fpp_point_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (point_count_ff[IDX_BITS-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fpp_sq_unit u_sq (
      .clock    (clock),
      .point_a  (pi_ff),
      .point_b  (mem_rd_data),
      .axis_sel (axis_sel),
      .sq_prod  (sq_prod)
   );

   fpp_isqrt u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (best_sq_ff),
      .done     (root_done),
      .root     (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_bus.last_point) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = (point_count_ff < CNT_BITS'(2)) ? ST_ROOT_GO : ST_LOAD_I;
         end
         ST_LOAD_I: state_in = ST_GET_I;
         ST_GET_I:  state_in = ST_DX;
         ST_DX:     state_in = ST_DY;
         ST_DY:     state_in = ST_DZ;
         ST_DZ:     state_in = ST_CMP;
         ST_CMP: begin
            if (j_plus1 < point_count_ff) begin
               state_in = ST_DX;
            end else if (i_plus2 < point_count_ff) begin
               state_in = ST_LOAD_I;
            end else begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: begin
            if (root_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register updates
   always_comb begin
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = i_ff[IDX_BITS-1:0];
      axis_sel       = AXIS_X;
      root_start     = 1'b0;
      point_count_in = point_count_ff;
      overflow_in    = overflow_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      pi_in          = pi_ff;
      acc_in         = acc_ff;
      best_sq_in     = best_sq_ff;
      best_first_in  = best_first_ff;
      best_second_in = best_second_ff;
      best_pi_in     = best_pi_ff;
      best_pj_in     = best_pj_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (point_count_ff < CNT_BITS'(MAX_POINTS)) begin
                  mem_wr_en      = 1'b1;
                  point_count_in = point_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            best_sq_in     = '0;
            best_first_in  = '0;
            best_second_in = '0;
            i_in           = '0;
         end
         ST_LOAD_I: begin
            mem_rd_en = 1'b1;
         end
         ST_GET_I: begin
            pi_in       = mem_rd_data;
            j_in        = i_plus1;
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_plus1[IDX_BITS-1:0];
         end
         ST_DX: begin
            axis_sel = AXIS_X;
         end
         ST_DY: begin
            axis_sel = AXIS_Y;
            acc_in   = SUM_BITS'(sq_prod);
         end
         ST_DZ: begin
            axis_sel = AXIS_Z;
            acc_in   = acc_ff + SUM_BITS'(sq_prod);
         end
         ST_CMP: begin
            // strictly larger only, so the earliest pair keeps a tie
            if (total_keep > best_sq_ff) begin
               best_sq_in     = total_keep;
               best_first_in  = i_ff[IDX_BITS-1:0];
               best_second_in = j_ff[IDX_BITS-1:0];
               best_pi_in     = pi_ff;
               best_pj_in     = mem_rd_data;
            end
            if (j_plus1 < point_count_ff) begin
               j_in        = j_plus1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = j_plus1[IDX_BITS-1:0];
            end else if (i_plus2 < point_count_ff) begin
               i_in = i_plus1;
            end
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
         end
         ST_ROOT_WAIT: begin
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.first_index  = found ? OUT_INDEX_BITS'(best_first_ff) : '0;
               rsp_data_in.second_index = found ? OUT_INDEX_BITS'(best_second_ff) : '0;
               rsp_data_in.first_pt     = found ? best_pi_ff : '0;
               rsp_data_in.second_pt    = found ? best_pj_ff : '0;
               rsp_data_in.squared      = ((best_sq_ff >> OUT_SQ_BITS) != '0) ?
                                          '1 : OUT_SQ_BITS'(best_sq_ff);
               rsp_data_in.distance     = OUT_DIST_BITS'(root);
               rsp_data_in.found        = found;
               rsp_data_in.dropped      = overflow_ff;
               point_count_in           = '0;
               overflow_in              = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         overflow_ff    <= 1'b0;
         best_sq_ff     <= '0;
         best_first_ff  <= '0;
         best_second_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         overflow_ff    <= overflow_in;
         best_sq_ff     <= best_sq_in;
         best_first_ff  <= best_first_in;
         best_second_ff <= best_second_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      pi_ff       <= pi_in;
      acc_ff      <= acc_in;
      best_pi_ff  <= best_pi_in;
      best_pj_ff  <= best_pj_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.first_index      = rsp_data_ff.first_index;
   assign rsp_bus.second_index     = rsp_data_ff.second_index;
   assign rsp_bus.first_x          = rsp_data_ff.first_pt.x;
   assign rsp_bus.first_y          = rsp_data_ff.first_pt.y;
   assign rsp_bus.first_z          = rsp_data_ff.first_pt.z;
   assign rsp_bus.second_x         = rsp_data_ff.second_pt.x;
   assign rsp_bus.second_y         = rsp_data_ff.second_pt.y;
   assign rsp_bus.second_z         = rsp_data_ff.second_pt.z;
   assign rsp_bus.squared_distance = rsp_data_ff.squared;
   assign rsp_bus.distance         = rsp_data_ff.distance;
   assign rsp_bus.pair_found       = rsp_data_ff.found;
   assign rsp_bus.points_dropped   = rsp_data_ff.dropped;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count beyond store capacity");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (best_sq_ff != '0) |-> (best_first_ff < best_second_ff))
      else $error("best pair indices out of order");

   a_pair_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DX) |-> ((j_ff > i_ff) && (j_ff < point_count_ff)))
      else $error("pair walk left the loaded set");

   a_search_done_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && slot_free |=> rsp_valid_ff && (point_count_ff == '0))
      else $error("result not posted or set not cleared");
`endif

endmodule

@@ tb/sv/farthest_point_pair_tb.sv @@
// testbench for farthest_point_pair: directed and random point sets against an in-bench pair search
module farthest_point_pair_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpp_pkg::*;

   localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
   localparam int PHASE_POINTS  = 270;
   localparam int DRAIN_CYCLES  = 64;
   localparam int PRINT_LIMIT   = 100;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NEAR,
      SPREAD_EDGE
   } spread_type;

   typedef struct {
      logic [OUT_INDEX_BITS-1:0] first_index;
      logic [OUT_INDEX_BITS-1:0] second_index;
      point_type                 first_pt;
      point_type                 second_pt;
      logic [OUT_SQ_BITS-1:0]    squared;
      logic [OUT_DIST_BITS-1:0]  length;
      logic                      found;
      logic                      dropped;
   } pair_result_type;

   class farthest_pair_board;
      point_type       set_points[$];
      bit              set_overflowed;
      pair_result_type pending_pairs[$];
      int              errors;

      function new();
         errors = 0;
         set_overflowed = 1'b0;
      endfunction

      function logic [63:0] pair_squared(point_type a, point_type b);
         longint dx, dy, dz;
         dx = longint'(a.x) - longint'(b.x);
         dy = longint'(a.y) - longint'(b.y);
         dz = longint'(a.z) - longint'(b.z);
         return dx * dx + dy * dy + dz * dz;
      endfunction

      // build the root one bit at a time from the top
      function logic [63:0] floor_root(logic [63:0] v);
         logic [63:0] root, trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function pair_result_type farthest_pair();
         pair_result_type r;
         logic [63:0]     best, s;
         int              bi, bj;
         r = '{default: '0};
         best = '0;
         bi = 0;
         bj = 0;
         for (int i = 0; i + 1 < set_points.size(); i++) begin
            for (int j = i + 1; j < set_points.size(); j++) begin
               s = pair_squared(set_points[i], set_points[j]);
               // strict compare keeps the earliest pair on a tie
               if (s > best) begin
                  best = s;
                  bi = i;
                  bj = j;
               end
            end
         end
         if (best != 0) begin
            r.first_index  = OUT_INDEX_BITS'(bi);
            r.second_index = OUT_INDEX_BITS'(bj);
            r.first_pt     = set_points[bi];
            r.second_pt    = set_points[bj];
            r.squared      = (best >> OUT_SQ_BITS) != 0 ? '1 : best[OUT_SQ_BITS-1:0];
            r.length       = OUT_DIST_BITS'(floor_root(best));
            r.found        = 1'b1;
         end
         r.dropped = set_overflowed;
         return r;
      endfunction

      function void note_point(point_type p, bit is_last);
         if (set_points.size() < MAX_POINTS) set_points = {set_points, p};
         else set_overflowed = 1'b1;
         if (is_last) begin
            pending_pairs = {pending_pairs, farthest_pair()};
            set_points.delete();
            set_overflowed = 1'b0;
         end
      endfunction

      task report(string msg);
         if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task compare(string field, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", field, got, want));
      endtask

      task check_result(pair_result_type got);
         pair_result_type want;
         if (pending_pairs.size() == 0) begin
            report("result beat with no point set closed");
            return;
         end
         want = pending_pairs.pop_front();
         compare("first_index", got.first_index, want.first_index);
         compare("second_index", got.second_index, want.second_index);
         compare("first_x", got.first_pt.x, want.first_pt.x);
         compare("first_y", got.first_pt.y, want.first_pt.y);
         compare("first_z", got.first_pt.z, want.first_pt.z);
         compare("second_x", got.second_pt.x, want.second_pt.x);
         compare("second_y", got.second_pt.y, want.second_pt.y);
         compare("second_z", got.second_pt.z, want.second_pt.z);
         compare("squared_distance", got.squared, want.squared);
         compare("distance", got.length, want.length);
         compare("pair_found", got.found, want.found);
         compare("points_dropped", got.dropped, want.dropped);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;

   farthest_pair_board board;

   fpp_req_if req_ch ();
   fpp_rsp_if rsp_ch ();

   farthest_point_pair uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic point_type pt(int x, int y, int z);
      point_type p;
      p.x = COORD_BITS'(x);
      p.y = COORD_BITS'(y);
      p.z = COORD_BITS'(z);
      return p;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] random_coord(spread_type spread);
      int pick;
      pick = $urandom_range(0, 7);
      case (spread)
         SPREAD_NEAR: return COORD_BITS'(int'($urandom_range(0, 2047)) - 1024);
         SPREAD_EDGE: begin
            case (pick)
               0: return COORD_BITS'(COORD_MIN);
               1: return COORD_BITS'(COORD_MAX);
               2: return '0;
               3: return '1;
               4: return COORD_BITS'(1);
               default: return COORD_BITS'($urandom());
            endcase
         end
         default: return COORD_BITS'($urandom());
      endcase
   endfunction

   task automatic send_point(point_type p, bit is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.coord_x    <= p.x;
      req_ch.coord_y    <= p.y;
      req_ch.coord_z    <= p.z;
      req_ch.last_point <= is_last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.note_point(p, is_last);
   endtask

   task automatic send_set(point_type pts[$]);
      foreach (pts[k]) send_point(pts[k], k == pts.size() - 1);
   endtask

   // random set: sometimes tiny, sometimes one repeated point, often with duplicates
   task automatic send_random_set(output int size);
      point_type  pts[$];
      point_type  p;
      spread_type spread;
      bit         all_same;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      spread = spread_type'($urandom_range(0, 2));
      all_same = ($urandom_range(0, 15) == 0);
      for (int k = 0; k < size; k++) begin
         if (k > 0 && (all_same || $urandom_range(0, 4) == 0))
            p = pts[$urandom_range(0, k - 1)];
         else
            p = pt(random_coord(spread), random_coord(spread), random_coord(spread));
         pts = {pts, p};
      end
      send_set(pts);
   endtask

   initial begin
      pair_result_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.first_index  = rsp_ch.first_index;
            got.second_index = rsp_ch.second_index;
            got.first_pt     = {rsp_ch.first_x, rsp_ch.first_y, rsp_ch.first_z};
            got.second_pt    = {rsp_ch.second_x, rsp_ch.second_y, rsp_ch.second_z};
            got.squared      = rsp_ch.squared_distance;
            got.length       = rsp_ch.distance;
            got.found        = rsp_ch.pair_found;
            got.dropped      = rsp_ch.points_dropped;
            board.check_result(got);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("[farthest_point_pair] ERROR");
      $finish;
   end

   initial begin
      int        size;
      int        sent;
      board = new();
      send_idle_pct = 8;
      recv_idle_pct = 75;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.coord_x    <= '0;
      req_ch.coord_y    <= '0;
      req_ch.coord_z    <= '0;
      req_ch.last_point <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // lone point, two equal points, opposite corners
      send_set('{pt(1, 2, 3)});
      send_set('{pt(0, 0, 0), pt(0, 0, 0)});
      send_set('{pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MAX, COORD_MAX)});
      // ties: the earliest pair must win
      send_set('{pt(0, 0, 0), pt(1, 0, 0), pt(0, 0, 0)});
      send_set('{pt(5, 5, 5), pt(5, 5, 5), pt(-5, -5, -5)});
      send_set('{pt(COORD_MAX, COORD_MIN, 0), pt(COORD_MIN, COORD_MAX, -1),
                 pt(0, 0, COORD_MAX), pt(-256, 256, COORD_MIN)});
      send_set('{pt(100, -200, 300), pt(100, -200, 300), pt(100, -200, 300)});

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 8 : 0;
         sent = 0;
         while (sent < PHASE_POINTS) begin
            send_random_set(size);
            sent += size;
         end
      end
      req_ch.valid <= 1'b0;

      while (board.pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_pairs.size() == 0) begin
         $display("[farthest_point_pair] OK");
      end else begin
         $display("[farthest_point_pair] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/fpp_pkg.sv
src/fpp_channels.sv
src/fpp_point_mem.sv
src/fpp_sq_unit.sv
src/fpp_isqrt.sv
src/farthest_point_pair.sv
tb/sv/farthest_point_pair_tb.sv
